/* rtl/bce_pkg.sv */
// Shared constants, types and the logarithm table for the cross-entropy unit.
// Used by every module in rtl; depends on nothing else.
package bce_pkg;

    localparam int LOG_TABLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF     = 24;
    localparam int LN2_Q16            = 45426;
    localparam int SUM_W              = 48;
    localparam int FLOOR_RESET        = -1811000;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_AVG   = 3'd1,
        REG_USEW  = 3'd2,
        REG_COUNT = 3'd3,
        REG_FLOOR = 3'd4
    } t_reg_idx;

    // Configuration bundle passed from the top level to the datapath.
    typedef struct packed {
        logic               mode;
        logic               avg;
        logic               usew;
        logic [24:0]        count;
        logic signed [23:0] floor_q16;
    } t_cfg;

    // Restoring division, evaluated only while the constant table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q, r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], a[j]};
            if (r >= b) begin
                r = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/2^bits) in Q16, rounded to nearest, evaluated by series.
    function automatic logic [15:0] log_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] n, z, z2, term, acc, k, ii;
        n = 64'd1 << bits;
        ii = 64'(i);
        z = udiv64(ii << 32, (n << 1) + ii);
        z2 = (z * z) >> 32;
        term = z;
        acc = 64'd0;
        k = 64'd1;
        for (int s = 0; s < 40; s++) begin
            if (term != 64'd0) begin
                acc = acc + udiv64(term, k);
                term = (term * z2) >> 32;
                k = k + 64'd2;
            end
        end
        return 16'(((acc << 1) + 64'd32768) >> 16);
    endfunction

endpackage

/* rtl/bce_log.sv */
// Logarithm unit: ln(v/65536) in Q16 through a priority encoder and a table.
// Depends on bce_pkg.
module bce_log import bce_pkg::*; #(
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic [16:0]        i_v,
    input  logic signed [23:0] i_floor,
    output logic signed [23:0] o_ln
);
    localparam int N = 1 << LOG_TABLE_BITS;

    logic [15:0] c_tab [N];
    logic [4:0]  w_p;
    logic [LOG_TABLE_BITS-1:0] w_idx;
    logic [16+LOG_TABLE_BITS:0] w_sh;
    logic signed [23:0] n_ln;

    // Constant table built at elaboration.
    for (genvar g = 0; g < N; g++) begin : g_tab
        localparam logic [15:0] ENTRY = log_entry(g, LOG_TABLE_BITS);
        assign c_tab[g] = ENTRY;
    end

    // Position of the leading one.
    always_comb begin
        w_p = 5'd0;
        for (int b = 1; b <= 16; b++) begin
            if (i_v[b]) w_p = 5'(b);
        end
    end

    // Mantissa bits below the leading one, aligned to the table index.
    assign w_sh  = {{LOG_TABLE_BITS{1'b0}}, i_v} << LOG_TABLE_BITS;
    assign w_idx = LOG_TABLE_BITS'(w_sh >> w_p);

    always_comb begin
        if (i_v == 17'd0) begin
            n_ln = i_floor;
        end else begin
            n_ln = 24'(($signed({1'b0, w_p}) - 6'sd16) * LN2_Q16) +
                   $signed({8'd0, c_tab[w_idx]});
        end
    end

    // Registered result.
    always_ff @(posedge i_clk) begin
        o_ln <= n_ln;
    end
endmodule

/* rtl/bce_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bce_pkg.
module bce_div import bce_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_try;

    assign w_try = {r_rem[DW-1:0], r_q[NW-1]};

    // Shift a numerator bit into the remainder and subtract where it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_try >= {1'b0, r_den}) begin
                    r_rem <= w_try - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_q;
endmodule

/* rtl/bce_mul.sv */
// Shift-add multiplier: one bit of the multiplier operand per cycle.
// Depends on bce_pkg.
module bce_mul import bce_pkg::*; #(
    parameter int AW = 64,
    parameter int BW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic          o_done,
    output logic [AW-1:0] o_prod
);
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0] r_acc;
    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    // Add the shifted multiplicand wherever a multiplier bit is set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= CW'(BW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;
endmodule

/* rtl/binary_cross_entropy_unit.sv */
// Binary cross-entropy unit: loss accumulation or per-element gradient.
// Results are built with serial multiplies (three per loss element, two or three per gradient
// element) and a serial divide. One element at a time: the input is ready again after the
// accumulate step for a loss element without result, else once the result is handed to the
// output register; a full output register holds the next result and stalls the input.
module binary_cross_entropy_unit import bce_pkg::*; #(
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // prob[16:0], target[33:17], weight[49:34], zero pad
    input  logic        s_axis_tlast,  // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // loss_value[47:0], grad_value[79:48]
    output logic        m_axis_tlast,  // final_res
    output logic        m_axis_tuser,  // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam logic [32:0] CAP     = 33'd1 << COUNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_LOGW, S_LOG, S_M1, S_M2, S_M3, S_M4, S_ACC,
        S_GD, S_GN, S_GDIV, S_GFIN, S_AVG, S_OUT
    } t_state;

    t_state r_state;
    t_cfg   r_cfg;
    logic [16:0] r_x, r_y;
    logic [15:0] r_w;
    logic        r_last;
    logic signed [23:0] w_lnx, w_ln1x;
    logic signed [63:0] r_s;
    logic [63:0] r_sum;
    logic        r_ovf;
    logic        r_neg;
    logic [63:0] r_num;
    logic [79:0] r_rdata;
    logic        r_rsat, r_rlast;

    logic        r_mstart, r_dstart;
    logic [63:0] r_ma, r_na, r_dd;
    logic [31:0] r_mb;
    logic        w_mdone, w_ddone;
    logic [63:0] w_prod, w_quo;
    logic [32:0] w_div;
    logic [16:0] w_1x;
    logic [63:0] w_term, w_tmp;

    assign pready = 1'b1;
    assign w_1x   = 17'h10000 - r_x;

    // Effective averaging divisor.
    always_comb begin
        w_div = {8'd0, r_cfg.count};
        if (w_div == 33'd0) w_div = 33'd1;
        if (w_div > CAP) w_div = CAP;
    end

    bce_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lx (
        .i_clk(i_clk), .i_v(r_x), .i_floor(r_cfg.floor_q16), .o_ln(w_lnx));
    bce_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_l1x (
        .i_clk(i_clk), .i_v(w_1x), .i_floor(r_cfg.floor_q16), .o_ln(w_ln1x));

    bce_mul #(.AW(64), .BW(32)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_a(r_ma),
        .i_b(r_mb), .o_done(w_mdone), .o_prod(w_prod));

    bce_div #(.NW(64), .DW(64)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_na),
        .i_den(r_dd), .o_done(w_ddone), .o_quo(w_quo));

    assign s_axis_tready = (r_state == S_IDLE);

    // Register readback.
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_MODE:  prdata = {31'd0, r_cfg.mode};
            REG_AVG:   prdata = {31'd0, r_cfg.avg};
            REG_USEW:  prdata = {31'd0, r_cfg.usew};
            REG_COUNT: prdata = {7'd0, r_cfg.count};
            REG_FLOOR: prdata = {{8{r_cfg.floor_q16[23]}}, r_cfg.floor_q16};
            default:   prdata = '0;
        endcase
    end

    assign w_term = w_prod >> 16;
    assign w_tmp  = r_sum + w_term;

    // Sequencer, accumulator and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= '{mode: 1'b0, avg: 1'b1, usew: 1'b0, count: 25'd1,
                         floor_q16: 24'(FLOOR_RESET)};
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_MODE:  r_cfg.mode <= pwdata[0];
                    REG_AVG:   r_cfg.avg <= pwdata[0];
                    REG_USEW:  r_cfg.usew <= pwdata[0];
                    REG_COUNT: r_cfg.count <= pwdata[24:0];
                    REG_FLOOR: r_cfg.floor_q16 <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_x <= (s_axis_tdata[16:0] > 17'h10000) ? 17'h10000 : s_axis_tdata[16:0];
                    r_y <= (s_axis_tdata[33:17] > 17'h10000) ? 17'h10000 : s_axis_tdata[33:17];
                    r_w <= r_cfg.usew ? s_axis_tdata[49:34] : 16'd256;
                    r_last <= s_axis_tlast;
                    r_state <= S_LOGW;
                end
                // The log units see the new operands in this cycle.
                S_LOGW: r_state <= S_LOG;
                S_LOG: begin
                    // Registered logs are valid now.
                    if (r_cfg.mode) begin
                        r_neg <= r_y > r_x;
                        r_ma <= (r_y > r_x) ? 64'(r_y - r_x) : 64'(r_x - r_y);
                        r_mb <= 32'(r_w);
                    end else begin
                        r_ma <= 64'(signed'(w_lnx));
                        r_mb <= 32'(r_y);
                    end
                    r_mstart <= 1'b1;
                    r_state <= r_cfg.mode ? S_GN : S_M1;
                end
                S_M1: if (w_mdone) begin
                    r_s <= signed'(w_prod);
                    r_ma <= 64'(signed'(w_ln1x));
                    r_mb <= 32'(17'h10000 - r_y);
                    r_mstart <= 1'b1;
                    r_state <= S_M2;
                end
                S_M2: if (w_mdone) begin
                    r_s <= r_s + signed'(w_prod);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_ma <= (r_s < 0) ? 64'(-r_s) : 64'd0;
                    r_mb <= 32'(r_w);
                    r_mstart <= 1'b1;
                    r_state <= S_M4;
                end
                S_M4: if (w_mdone) r_state <= S_ACC;
                S_ACC: begin
                    if (w_tmp > SUM_MAX) begin
                        r_sum <= SUM_MAX;
                        r_ovf <= 1'b1;
                    end else begin
                        r_sum <= w_tmp;
                    end
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_cfg.avg) begin
                        r_na <= (w_tmp > SUM_MAX) ? SUM_MAX : w_tmp;
                        r_dd <= 64'(w_div);
                        r_dstart <= 1'b1;
                        r_state <= S_AVG;
                    end else begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: if (!r_cfg.avg || w_ddone) begin
                    r_rdata <= {32'd0, r_cfg.avg ? w_quo[47:0] : r_sum[47:0]};
                    r_rsat <= r_ovf;
                    r_rlast <= 1'b1;
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                    r_state <= S_OUT;
                end
                S_GN: if (w_mdone) begin
                    // Numerator done; now the denominator (1-x)*x.
                    r_num <= w_prod << 24;
                    r_ma <= 64'(w_1x);
                    r_mb <= 32'(r_x);
                    r_mstart <= 1'b1;
                    r_state <= S_GD;
                end
                S_GD: if (w_mdone) begin
                    if (r_cfg.avg) begin
                        r_ma <= w_prod;
                        r_mb <= 32'(w_div);
                        r_mstart <= 1'b1;
                    end
                    r_state <= S_GDIV;
                end
                S_GDIV: if (!r_cfg.avg || w_mdone) begin
                    r_na <= r_num;
                    r_dd <= w_prod;
                    if (r_num != 64'd0 && w_prod != 64'd0) r_dstart <= 1'b1;
                    r_state <= S_GFIN;
                end
                S_GFIN: if (r_na == 64'd0 || r_dd == 64'd0 || w_ddone) begin
                    logic [63:0] q, lim;
                    logic        sat;
                    lim = r_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    sat = 1'b0;
                    if (r_na == 64'd0) q = 64'd0;
                    else if (r_dd == 64'd0) begin q = lim; sat = 1'b1; end
                    else begin
                        q = w_quo;
                        if (q > lim) begin q = lim; sat = 1'b1; end
                    end
                    r_rdata <= {(r_neg ? (32'd0 - q[31:0]) : q[31:0]), 48'd0};
                    r_rsat <= sat;
                    r_rlast <= r_last;
                    r_state <= S_OUT;
                end
                // Hand the finished result over once the output register is free.
                S_OUT: if (!m_axis_tvalid) begin
                    m_axis_tdata <= r_rdata;
                    m_axis_tuser <= r_rsat;
                    m_axis_tlast <= r_rlast;
                    m_axis_tvalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* sim/testbench.sv */
// Self-checking testbench for binary_cross_entropy_unit: loss accumulation and gradient modes.
// Depends on rtl/bce_pkg.sv and rtl/binary_cross_entropy_unit.sv; reads no files.
`timescale 1ns / 100ps

module testbench;
    import bce_pkg::*;

    localparam int          TAB_BITS   = 10;
    localparam int          CNT_BITS   = 24;
    localparam longint      LN2_FIX    = 45426;
    localparam logic [63:0] ACC_MAX    = (64'd1 << 48) - 64'd1;
    localparam int          SETTLE_CYC = 400;
    localparam int          LONG_HOLD  = 3000;
    localparam longint      CYCLE_CAP  = 2000000;

    typedef struct packed {
        logic [16:0] prob;
        logic [16:0] target;
        logic [15:0] weight;
        logic        last;
    } t_elem;

    typedef struct packed {
        logic [47:0] loss;
        logic [31:0] grad;
        logic        sat;
        logic        fin;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // prob[16:0], target[33:17], weight[49:34], zero pad
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // loss_value[47:0], grad_value[79:48]
    logic        m_axis_tlast;   // final_res
    logic        m_axis_tuser;   // saturated
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binary_cross_entropy_unit uut (.*);

    // Predictor state: configuration copy, accumulator and the log table.
    logic               cfg_mode, cfg_avg, cfg_usew;
    logic [24:0]        cfg_count;
    logic signed [23:0] cfg_floor;
    logic [63:0]        loss_acc;
    logic               acc_ovf;
    logic [15:0]        ln_frac_tab [0:(1 << TAB_BITS) - 1];

    t_elem  pending_elems[$];
    t_res   expected_results[$];
    int     error_count;
    int     send_idle_pct, recv_stall_pct;
    logic   hold_enable;
    int     hold_left;
    logic   elem_taken;
    longint cycle_no;

    // Clock and cycle limit.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_CAP) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ln(1 + i/2^TAB_BITS) in Q16 by the atanh series.
    function automatic logic [15:0] ln_frac(input int unsigned i);
        logic [63:0] n, z, z2, term, acc, k;
        n = 64'd1 << TAB_BITS;
        z = (64'(i) << 32) / ((n << 1) + 64'(i));
        z2 = (z * z) >> 32;
        term = z;
        acc = 0;
        k = 1;
        while (term != 0) begin
            acc = acc + term / k;
            term = (term * z2) >> 32;
            k = k + 2;
        end
        return 16'(((acc << 1) + 64'd32768) >> 16);
    endfunction

    // Natural log of v/65536 in Q16; zero maps to the configured floor.
    function automatic longint ln_fixed(input logic [16:0] v);
        int unsigned p, idx;
        p = 0;
        if (v == 0) return longint'(cfg_floor);
        while (p < 16 && (v >> (p + 1)) != 0) p++;
        if (p >= TAB_BITS) idx = (v >> (p - TAB_BITS)) & ((1 << TAB_BITS) - 1);
        else idx = (v << (TAB_BITS - p)) & ((1 << TAB_BITS) - 1);
        return (longint'(p) - 16) * LN2_FIX + longint'(ln_frac_tab[idx]);
    endfunction

    function automatic logic [63:0] avg_divisor();
        logic [63:0] n;
        n = 64'(cfg_count);
        if (n == 0) n = 1;
        if (n > (64'd1 << CNT_BITS)) n = 64'd1 << CNT_BITS;
        return n;
    endfunction

    // Works out the result, if any, that one accepted element causes.
    task automatic predict_bce(input t_elem e);
        logic [16:0] x, y;
        logic [63:0] w, mag, diff, num, den, lim, q;
        longint      s;
        logic        neg, sat;
        t_res        r;
        x = (e.prob > 17'd65536) ? 17'd65536 : e.prob;
        y = (e.target > 17'd65536) ? 17'd65536 : e.target;
        w = cfg_usew ? 64'(e.weight) : 64'd256;
        r = '0;
        if (!cfg_mode) begin
            s = longint'(y) * ln_fixed(x) + longint'(65536 - y) * ln_fixed(17'd65536 - x);
            mag = (s < 0) ? 64'(-s) : 64'd0;
            loss_acc = loss_acc + ((mag * w) >> 16);
            if (loss_acc > ACC_MAX) begin
                loss_acc = ACC_MAX;
                acc_ovf = 1'b1;
            end
            if (e.last) begin
                r.loss = cfg_avg ? 48'(loss_acc / avg_divisor()) : 48'(loss_acc);
                r.sat = acc_ovf;
                r.fin = 1'b1;
                expected_results.push_back(r);
                loss_acc = 0;
                acc_ovf = 1'b0;
            end
        end else begin
            neg = y > x;
            diff = neg ? 64'(y - x) : 64'(x - y);
            num = (diff * w) << 24;
            den = 64'(17'd65536 - x) * 64'(x);
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            sat = 1'b0;
            if (cfg_avg) den = den * avg_divisor();
            if (num == 0) q = 0;
            else if (den == 0) begin
                q = lim;
                sat = 1'b1;
            end else begin
                q = num / den;
                if (q > lim) begin
                    q = lim;
                    sat = 1'b1;
                end
            end
            r.grad = neg ? (32'd0 - q[31:0]) : q[31:0];
            r.sat = sat;
            r.fin = e.last;
            expected_results.push_back(r);
        end
    endtask

    // Sender: presents the next element at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || elem_taken) begin
            if (pending_elems.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_elem e;
                e = pending_elems.pop_front();
                s_axis_tdata <= {6'd0, e.weight, e.target, e.prob};
                s_axis_tlast <= e.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Accepted requests feed the predictor.
    always @(posedge i_clk) begin
        elem_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            predict_bce({s_axis_tdata[16:0], s_axis_tdata[33:17], s_axis_tdata[49:34],
                         s_axis_tlast});
        end
    end

    // Receiver: random stalls plus one long hold-off while the sender keeps offering.
    always @(negedge i_clk) begin
        if (hold_enable && hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            t_res got, want;
            got = {m_axis_tdata[47:0], m_axis_tdata[79:48], m_axis_tuser, m_axis_tlast};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result loss=%h grad=%h sat=%b fin=%b", $time,
                         got.loss, got.grad, got.sat, got.fin);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.loss !== want.loss) begin
                    $display("%0t: loss_value expected %h actual %h", $time, want.loss, got.loss);
                    error_count++;
                end
                if (got.grad !== want.grad) begin
                    $display("%0t: grad_value expected %h actual %h", $time, want.grad, got.grad);
                    error_count++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
                    error_count++;
                end
                if (got.fin !== want.fin) begin
                    $display("%0t: final_res expected %b actual %b", $time, want.fin, got.fin);
                    error_count++;
                end
            end
        end
    end

    // Register write over the configuration port; the predictor copy follows.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:  cfg_mode = val[0];
            REG_AVG:   cfg_avg = val[0];
            REG_USEW:  cfg_usew = val[0];
            REG_COUNT: cfg_count = val[24:0];
            REG_FLOOR: cfg_floor = val[23:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic m, input logic a, input logic u,
                           input logic [24:0] cnt, input logic [23:0] fl);
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_AVG, 32'(a));
        write_reg(REG_USEW, 32'(u));
        write_reg(REG_COUNT, 32'(cnt));
        write_reg(REG_FLOOR, 32'(fl));
    endtask

    // Waits until every element is sent and every result is back, then lets the unit settle.
    task automatic drain();
        while (pending_elems.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    function automatic logic [16:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(1, 255));
            4: return 17'($urandom_range(65280, 65535));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic t_elem rand_elem(input logic loss_mode);
        t_elem e;
        e.prob = rand_q16();
        e.target = ($urandom_range(0, 2) == 0) ? rand_q16() :
                   (($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0);
        case ($urandom_range(0, 5))
            0: e.weight = 16'd0;
            1: e.weight = 16'hFFFF;
            default: e.weight = 16'($urandom_range(0, 65535));
        endcase
        e.last = loss_mode ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
        return e;
    endfunction

    task automatic push_elem(input int p, input int t, input int w, input logic l);
        pending_elems.push_back({17'(p), 17'(t), 16'(w), l});
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        t_elem e;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            e = rand_elem(!cfg_mode);
            if (k == n - 1) e.last = 1'b1;
            pending_elems.push_back(e);
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < (1 << TAB_BITS); i++) ln_frac_tab[i] = ln_frac(i);
        cycle_no = 0;
        error_count = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        elem_taken = 1'b0;
        hold_enable = 1'b0;
        hold_left = LONG_HOLD;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_mode = 1'b0;
        cfg_avg = 1'b1;
        cfg_usew = 1'b0;
        cfg_count = 25'd1;
        cfg_floor = 24'(FLOOR_RESET);
        loss_acc = 0;
        acc_ovf = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Loss mode at reset settings: log of zero on both sides, clamped inputs.
        push_elem(0, 0, 0, 1'b0);
        push_elem(0, 65536, 0, 1'b0);
        push_elem(65536, 0, 0, 1'b1);
        push_elem(65536, 65536, 0, 1'b1);
        push_elem(131071, 131071, 0, 1'b1);
        push_elem(32768, 32768, 0, 1'b0);
        push_elem(1, 0, 0, 1'b1);
        drain();

        // Weight extremes with the lowest floor, no averaging.
        set_cfg(1'b0, 1'b0, 1'b1, 25'd3, 24'h800000);
        push_elem(0, 65536, 16'hFFFF, 1'b0);
        push_elem(40000, 20000, 16'h0000, 1'b1);
        push_elem(65535, 65536, 16'h0100, 1'b1);
        drain();

        // Accumulator overflow: a long frame of maximal terms.
        for (int k = 0; k < 520; k++) push_elem(0, 65536, 16'hFFFF, k == 519);
        drain();

        // Positive floor: negative terms count as zero; divisor zero reads as one.
        set_cfg(1'b0, 1'b1, 1'b1, 25'd0, 24'h7FFFFF);
        random_phase(50, 69, 0);

        set_cfg(1'b0, 1'b1, 1'b0, 25'h1FFFFFF, 24'(-$urandom_range(1, 8388608)));
        random_phase(50, 0, 69);

        // Gradient mode: edge probabilities, zero weight, then a long receiver hold-off.
        set_cfg(1'b1, 1'b0, 1'b1, 25'd1, 24'(FLOOR_RESET));
        push_elem(0, 0, 16'hFFFF, 1'b0);
        push_elem(0, 65536, 16'hFFFF, 1'b0);
        push_elem(65536, 0, 16'hFFFF, 1'b1);
        push_elem(0, 65536, 16'h0000, 1'b0);
        push_elem(1, 65536, 16'hFFFF, 1'b0);
        push_elem(65535, 0, 16'hFFFF, 1'b1);
        push_elem(32768, 32768, 16'h1234, 1'b0);
        hold_enable = 1'b1;
        random_phase(50, 27, 27);

        set_cfg(1'b1, 1'b1, 1'b1, 25'd16777216, 24'(FLOOR_RESET));
        random_phase(50, 0, 0);

        set_cfg(1'b1, 1'b1, 1'b0, 25'($urandom_range(1, 7)), 24'(FLOOR_RESET));
        random_phase(50, 69, 0);

        set_cfg(1'b0, 1'b1, 1'b1, 25'd5, 24'(FLOOR_RESET));
        random_phase(50, 27, 27);

        if (expected_results.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
